>>> src/dfu_pkg.sv
// ----------------------------------------------------------------------------
// dfu_pkg: shared constants and types for the detrended fluctuation unit
// Field widths, register reset value and the status word of the serial units.
// ----------------------------------------------------------------------------
package dfu_pkg;

  localparam int MAX_WINDOW_DEF    = 64;
  localparam int INTERVAL_BITS_DEF = 12;

  localparam int RR_W       = 12;
  localparam int CFG_W      = 7;
  localparam int FLUCT_W    = 28;
  localparam int COUNT_W    = 24;
  localparam int TOTAL_W    = 56;
  localparam int FRAC_SHIFT = 16;

  localparam logic [CFG_W-1:0] WIN_RESET  = 7'd16;
  localparam int               MIN_WINDOW = 4;

  localparam logic [FLUCT_W-1:0] FLUCT_MAX = {FLUCT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

>>> src/dfu_channels.sv
// ----------------------------------------------------------------------------
// dfu_channels: valid/ready channels of the detrended fluctuation unit
// Configuration write channel, interval input channel and result channel.
// ----------------------------------------------------------------------------
interface dfu_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dfu_pkg::CFG_W-1:0]  window_size;
  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

interface dfu_in_if;
  logic                      valid;
  logic                      ready;
  logic [dfu_pkg::RR_W-1:0]  rr_ms;
  logic                      last_interval;
  modport source (output valid, output rr_ms, output last_interval, input ready);
  modport sink   (input valid, input rr_ms, input last_interval, output ready);
endinterface

interface dfu_out_if;
  logic                         valid;
  logic                         ready;
  logic [dfu_pkg::FLUCT_W-1:0]  fluctuation;
  logic [dfu_pkg::COUNT_W-1:0]  windows_used;
  logic                         no_window;
  modport source (output valid, output fluctuation, output windows_used,
                  output no_window, input ready);
  modport sink   (input valid, input fluctuation, input windows_used,
                  input no_window, output ready);
endinterface

>>> src/detrended_fluctuation_unit.sv
// ----------------------------------------------------------------------------
// detrended_fluctuation_unit: single-scale DFA-1 over a stream of RR intervals
// Integrates intervals into a per-window profile, detrends each full window in
// closed form and reports the RMS residual on the word marked last.
// ----------------------------------------------------------------------------
//
//  channel    | dir | words carried                         | accepted when
//  -----------+-----+---------------------------------------+----------------
//  cfg        | in  | window_size (box size, clamped)       | valid & ready
//  intervals  | in  | rr_ms, last_interval                  | valid & ready
//  result     | out | fluctuation, windows_used, no_window  | valid & ready
//
//  Steps: an interval passes through the shift-add accumulation of the new
//  profile value. A word that closes a window adds ten serial multiplications,
//  their hand-over and a run of the restoring divider. The last word adds a
//  start step and, when windows were counted, a run of the divider and of the
//  bit-serial root, then the load of the output register.
//  Reset clears all series state and sets the box size to 16. cfg is always
//  ready. intervals is ready only between words; a waiting result stalls the
//  block only when the next result is ready to be loaded.
//
module detrended_fluctuation_unit #(
  parameter int MAX_WINDOW    = dfu_pkg::MAX_WINDOW_DEF,
  parameter int INTERVAL_BITS = dfu_pkg::INTERVAL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dfu_cfg_if.sink    cfg,
  dfu_in_if.sink     intervals,
  dfu_out_if.source  result
);

  // Widths follow from the largest box and interval
  localparam int MW   = $clog2(MAX_WINDOW + 1);
  localparam int LG   = $clog2(MAX_WINDOW);
  localparam int LPW  = INTERVAL_BITS + LG;
  localparam int SYW  = LPW + LG;
  localparam int SXW  = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
  localparam int SXYW = LPW + SXW;
  localparam int SYYW = 2 * LPW + LG;
  localparam int AW   = SYYW + MW;
  localparam int BW   = (SXYW + MW > SXW + SYW) ? SXYW + MW : SXW + SYW;
  localparam int KW   = 4 * MW;
  localparam int LW   = 5 * MW;
  localparam int NW   = AW + KW;
  localparam int B12W = 2 * BW + 4;
  localparam int RW   = (NW > B12W) ? NW : B12W;
  localparam int MPW0 = (SYW > KW) ? SYW : KW;
  localparam int MPW  = (BW > MPW0) ? BW : MPW0;
  localparam int FDW  = dfu_pkg::TOTAL_W + dfu_pkg::FRAC_SHIFT;
  localparam int DVW  = (RW > FDW) ? RW : FDW;
  localparam int DSW  = (LW > dfu_pkg::COUNT_W) ? LW : dfu_pkg::COUNT_W;
  localparam int SQW  = dfu_pkg::TOTAL_W;

  localparam logic [dfu_pkg::RR_W-1:0] RR_MASK =
    dfu_pkg::RR_W'((64'd1 << INTERVAL_BITS) - 64'd1);

  // Steps of the window-end sequence, one serial multiplication each
  localparam logic [3:0] OP_M_SYY  = 4'd0;
  localparam logic [3:0] OP_SY_SY  = 4'd1;
  localparam logic [3:0] OP_M_SXY  = 4'd2;
  localparam logic [3:0] OP_SX     = 4'd3;
  localparam logic [3:0] OP_SX_SY  = 4'd4;
  localparam logic [3:0] OP_B_SQ   = 4'd5;
  localparam logic [3:0] OP_M_M    = 4'd6;
  localparam logic [3:0] OP_K_D    = 4'd7;
  localparam logic [3:0] OP_A_K    = 4'd8;
  localparam logic [3:0] OP_M_K    = 4'd9;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ACC   = 10'b0000000010,
    S_MGO   = 10'b0000000100,
    S_MWAIT = 10'b0000001000,
    S_RDEC  = 10'b0000010000,
    S_DGO   = 10'b0000100000,
    S_DWAIT = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_SQRT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [dfu_pkg::CFG_W-1:0] window_size;
  logic [MW-1:0]             eff;

  // Series state
  logic [MW-1:0]   pos;
  logic [LPW-1:0]  lp;
  logic [SYW-1:0]  sy;
  logic [SXYW-1:0] sxy;
  logic [SYYW-1:0] syy;
  logic [dfu_pkg::TOTAL_W-1:0] total;
  logic [dfu_pkg::COUNT_W-1:0] cnt;
  logic            last_q;

  // Bit-serial accumulation of j*y and y*y
  logic [LPW-1:0]  mplier;
  logic [SXYW-1:0] mj;
  logic [SYYW-1:0] mlp;

  // Window-end working registers
  logic [3:0]      op;
  logic [AW-1:0]   a_val;
  logic [BW-1:0]   p_val;
  logic [BW-1:0]   bmag;
  logic [SXW-1:0]  sx;
  logic [RW-1:0]   b12;
  logic [KW-1:0]   kval;
  logic [LW-1:0]   lval;
  logic [RW-1:0]   n1;
  logic            fin_div;

  // Root
  logic [SQW-1:0]  sq_v;
  logic [SQW-1:0]  sq_res;
  logic [SQW-1:0]  sq_bit;
  logic [SQW:0]    sq_tmp;
  logic [dfu_pkg::FLUCT_W-1:0] fl_res;

  // Output word
  logic                          out_valid;
  logic [dfu_pkg::FLUCT_W-1:0]   out_fl;
  logic [dfu_pkg::COUNT_W-1:0]   out_cnt;
  logic                          out_nw;

  // Serial units
  logic [RW-1:0]   mul_a;
  logic [MPW-1:0]  mul_b;
  logic [RW-1:0]   mul_p;
  dfu_pkg::unit_status_t mul_st;
  logic [DVW-1:0]  div_num;
  logic [DSW-1:0]  div_den;
  logic [DVW-1:0]  div_q;
  dfu_pkg::unit_status_t div_st;

  logic [dfu_pkg::RR_W-1:0] rr_used;
  logic [MW-1:0]   pos_inc;
  logic [LPW-1:0]  lp_new;
  logic [BW-1:0]   q_val;
  logic [dfu_pkg::TOTAL_W-1:0] r_sat;
  logic [dfu_pkg::TOTAL_W:0]   sum_total;

  // Clamp the box size to the supported range
  always_comb begin
    if (int'(window_size) < dfu_pkg::MIN_WINDOW) begin
      eff = MW'(dfu_pkg::MIN_WINDOW);
    end else if (int'(window_size) > MAX_WINDOW) begin
      eff = MW'(MAX_WINDOW);
    end else begin
      eff = MW'(window_size);
    end
  end

  assign rr_used = intervals.rr_ms & RR_MASK;
  assign pos_inc = pos + 1'b1;
  assign lp_new  = lp + LPW'(rr_used);

  // Operand selection for each window-end step
  always_comb begin
    case (op)
      OP_M_SYY: begin mul_a = RW'(syy);   mul_b = MPW'(pos);               end
      OP_SY_SY: begin mul_a = RW'(sy);    mul_b = MPW'(sy);                end
      OP_M_SXY: begin mul_a = RW'(sxy);   mul_b = MPW'(pos);               end
      OP_SX:    begin mul_a = RW'(pos);
                      mul_b = MPW'({1'b0, pos} + (MW + 1)'(1));            end
      OP_SX_SY: begin mul_a = RW'(sx);    mul_b = MPW'(sy);                end
      OP_B_SQ:  begin mul_a = RW'(bmag);  mul_b = MPW'(bmag);              end
      OP_M_M:   begin mul_a = RW'(pos);   mul_b = MPW'(pos);               end
      OP_K_D:   begin mul_a = RW'(kval);  mul_b = MPW'(kval - 1'b1);       end
      OP_A_K:   begin mul_a = RW'(a_val); mul_b = MPW'(kval);              end
      OP_M_K:   begin mul_a = RW'(kval);  mul_b = MPW'(pos);               end
      default:  begin mul_a = '0;         mul_b = '0;                      end
    endcase
  end

  assign q_val = mul_p[BW-1:0];

  // Divider feeds: window residual or final mean square
  always_comb begin
    if (fin_div) begin
      div_num = DVW'(total) << dfu_pkg::FRAC_SHIFT;
      div_den = DSW'(cnt);
    end else begin
      div_num = DVW'(n1 - b12);
      div_den = DSW'(lval);
    end
  end

  assign r_sat = (div_q > DVW'(dfu_pkg::TOTAL_MAX)) ? dfu_pkg::TOTAL_MAX
                                                    : div_q[dfu_pkg::TOTAL_W-1:0];
  assign sum_total = {1'b0, total} + {1'b0, r_sat};
  assign sq_tmp    = {1'b0, sq_res} + {1'b0, sq_bit};

  dfu_serial_mul #(.A_W(RW), .B_W(MPW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_MGO),
    .a_in   (mul_a),
    .b_in   (mul_b),
    .prod   (mul_p),
    .status (mul_st)
  );

  dfu_serial_div #(.NUM_W(DVW), .DEN_W(DSW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DGO),
    .num_in (div_num),
    .den_in (div_den),
    .quo    (div_q),
    .status (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= dfu_pkg::WIN_RESET;
      out_valid   <= 1'b0;
      pos         <= '0;
      lp          <= '0;
      sy          <= '0;
      sxy         <= '0;
      syy         <= '0;
      total       <= '0;
      cnt         <= '0;
      last_q      <= 1'b0;
      fin_div     <= 1'b0;
      op          <= OP_M_SYY;
    end else begin
      if (cfg.valid) begin
        window_size <= cfg.window_size;
      end
      // Drop the taken word; the output stage reloads it itself
      if (result.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // Take one word: extend the profile and start the serial products
          if (intervals.valid) begin
            pos    <= pos_inc;
            lp     <= lp_new;
            sy     <= sy + SYW'(lp_new);
            last_q <= intervals.last_interval;
            mplier <= lp_new;
            mj     <= SXYW'(pos_inc);
            mlp    <= SYYW'(lp_new);
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          if (mplier == '0) begin
            if (pos >= eff) begin
              op    <= OP_M_SYY;
              state <= S_MGO;
            end else if (last_q) begin
              state <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            if (mplier[0]) begin
              sxy <= sxy + mj;
              syy <= syy + mlp;
            end
            mplier <= mplier >> 1;
            mj     <= mj << 1;
            mlp    <= mlp << 1;
          end
        end
        S_MGO: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_st.done) begin
            case (op)
              OP_M_SYY: a_val <= mul_p[AW-1:0];
              OP_SY_SY: a_val <= a_val - mul_p[AW-1:0];
              OP_M_SXY: p_val <= mul_p[BW-1:0];
              OP_SX:    sx    <= mul_p[SXW:1];
              OP_SX_SY: bmag  <= (p_val >= q_val) ? p_val - q_val : q_val - p_val;
              OP_B_SQ:  b12   <= (mul_p << 3) + (mul_p << 2);
              OP_M_M:   kval  <= mul_p[KW-1:0];
              OP_K_D:   kval  <= mul_p[KW-1:0];
              OP_A_K:   n1    <= mul_p;
              OP_M_K:   lval  <= mul_p[LW-1:0];
              default:  a_val <= a_val;
            endcase
            if (op == OP_M_K) begin
              state <= S_RDEC;
            end else begin
              op    <= op + 4'd1;
              state <= S_MGO;
            end
          end
        end
        S_RDEC: begin
          // A negative numerator floors to a zero residual
          if (n1 < b12) begin
            if (cnt != dfu_pkg::COUNT_MAX) begin
              cnt <= cnt + 1'b1;
            end
            pos   <= '0;
            lp    <= '0;
            sy    <= '0;
            sxy   <= '0;
            syy   <= '0;
            state <= last_q ? S_FIN : S_IDLE;
          end else begin
            fin_div <= 1'b0;
            state   <= S_DGO;
          end
        end
        S_DGO: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_st.done) begin
            if (!fin_div) begin
              total <= sum_total[dfu_pkg::TOTAL_W] ? dfu_pkg::TOTAL_MAX
                                                   : sum_total[dfu_pkg::TOTAL_W-1:0];
              if (cnt != dfu_pkg::COUNT_MAX) begin
                cnt <= cnt + 1'b1;
              end
              pos   <= '0;
              lp    <= '0;
              sy    <= '0;
              sxy   <= '0;
              syy   <= '0;
              state <= last_q ? S_FIN : S_IDLE;
            end else if (div_q[DVW-1:SQW] != '0) begin
              fl_res <= dfu_pkg::FLUCT_MAX;
              state  <= S_OUT;
            end else begin
              sq_v   <= div_q[SQW-1:0];
              sq_res <= '0;
              sq_bit <= SQW'(1) << (SQW - 2);
              state  <= S_SQRT;
            end
          end
        end
        S_FIN: begin
          if (cnt == '0) begin
            fl_res <= '0;
            state  <= S_OUT;
          end else begin
            fin_div <= 1'b1;
            state   <= S_DGO;
          end
        end
        S_SQRT: begin
          // Two radicand bits a step
          if (sq_bit == '0) begin
            fl_res <= dfu_pkg::FLUCT_W'(sq_res);
            state  <= S_OUT;
          end else begin
            if ({1'b0, sq_v} >= sq_tmp) begin
              sq_v   <= sq_v - sq_tmp[SQW-1:0];
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_OUT: begin
          // Hold until the output register is free, then drop the series
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_fl    <= fl_res;
            out_cnt   <= cnt;
            out_nw    <= (cnt == '0);
            pos       <= '0;
            lp        <= '0;
            sy        <= '0;
            sxy       <= '0;
            syy       <= '0;
            total     <= '0;
            cnt       <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg.ready           = 1'b1;
  assign intervals.ready     = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.fluctuation  = out_fl;
  assign result.windows_used = out_cnt;
  assign result.no_window    = out_nw;

endmodule

>>> src/dfu_serial_mul.sv
// ----------------------------------------------------------------------------
// dfu_serial_mul: shift-add multiplier, one multiplier bit per cycle
// Stops as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module dfu_serial_mul #(
  parameter int A_W = 64,
  parameter int B_W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [A_W-1:0]        a_in,
  input  logic [B_W-1:0]        b_in,
  output logic [A_W-1:0]        prod,
  output dfu_pkg::unit_status_t status
);

  logic           busy;
  logic [A_W-1:0] mcand;
  logic [B_W-1:0] mplier;
  logic [A_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && mplier == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a_in;
      mplier <= b_in;
      acc    <= '0;
    end else if (busy && mplier != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod        = acc;
  assign status.busy = busy;
  assign status.done = busy && (mplier == '0);

endmodule

>>> src/dfu_serial_div.sv
// ----------------------------------------------------------------------------
// dfu_serial_div: restoring divider, one quotient bit per cycle
// Divisor must be nonzero; the remainder is dropped.
// ----------------------------------------------------------------------------
module dfu_serial_div #(
  parameter int NUM_W = 78,
  parameter int DEN_W = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num_in,
  input  logic [DEN_W-1:0]      den_in,
  output logic [NUM_W-1:0]      quo,
  output dfu_pkg::unit_status_t status
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem, quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num_in;
      den <= den_in;
    end else if (busy && cnt != '0) begin
      rem <= ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = busy && (cnt == '0);

endmodule

>>> src/dfu_checker.sv
// ----------------------------------------------------------------------------
// dfu_checker: port-level checks for the detrended fluctuation unit
// Watches the interval and result channels only.
// ----------------------------------------------------------------------------
module dfu_checker (
  input logic       clk,
  input logic       rst,
  dfu_in_if.sink    intervals,
  dfu_out_if.source result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.fluctuation)
      && $stable(result.windows_used) && $stable(result.no_window))
    else $error("result word changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.no_window |->
      result.fluctuation == '0 && result.windows_used == '0)
    else $error("empty series reported nonzero fields");

  a_count_present: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.no_window |-> result.windows_used != '0)
    else $error("windows reported without a count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    intervals.valid && intervals.ready |=> !intervals.ready)
    else $error("interval taken while previous one still in work");

endmodule

bind detrended_fluctuation_unit dfu_checker u_dfu_checker (
  .clk       (clk),
  .rst       (rst),
  .intervals (intervals),
  .result    (result)
);
